@@ rtl/trd_pkg.sv @@
// shared types and constants for the tga run-length pixel decoder
package trd_pkg;

   // field widths
   localparam int BYTE_W     = 8;
   localparam int DIM_W      = 16;
   localparam int INDEX_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   // packet header decoding
   localparam logic [BYTE_W-1:0] RAW_LIMIT = 8'd128;
   localparam logic [BYTE_W-1:0] RUN_BIAS  = 8'd127;

   // pixel byte positions of the last byte of a pixel
   localparam logic [1:0] LAST_BYTE_3B = 2'd2;
   localparam logic [1:0] LAST_BYTE_4B = 2'd3;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FOUR_BYTE    = 2'd2
   } csr_index_type;

   // settings handed from the register block to the decoder
   typedef struct packed {
      logic               rearm;
      logic               four_byte;
      logic [INDEX_W-1:0] total;
   } cfg_type;

   // one result word
   typedef struct packed {
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [BYTE_W-1:0]  alpha;
      logic [BYTE_W-1:0]  span_length;
      logic [INDEX_W-1:0] start_index;
      logic               image_done;
      logic               overflow;
   } rsp_type;

endpackage

@@ rtl/trd_if.sv @@
// valid/ready channel interfaces for the coded byte input and the span output
interface trd_req_if import trd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface trd_rsp_if import trd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  red;
   logic [BYTE_W-1:0]  green;
   logic [BYTE_W-1:0]  blue;
   logic [BYTE_W-1:0]  alpha;
   logic [BYTE_W-1:0]  span_length;
   logic [INDEX_W-1:0] start_index;
   logic               image_done;
   logic               overflow;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output span_length, output start_index, output image_done,
                   output overflow, input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input span_length, input start_index, input image_done,
                   input overflow, output ready);
endinterface

@@ rtl/trd_csr.sv @@
// configuration registers and registered pixel count of the image
module trd_csr import trd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic               four_ff, four_in;
   logic [INDEX_W-1:0] total_ff, total_in;
   logic               rearm;

   // register write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      four_in   = four_ff;
      rearm     = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = csr_data;
               rearm    = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = csr_data;
               rearm     = 1'b1;
            end
            CSR_FOUR_BYTE: begin
               four_in = csr_data[0];
               rearm   = 1'b1;
            end
            default: begin
               rearm = 1'b0;
            end
         endcase
      end
   end

   // pixel count follows the register values that take effect this edge
   assign total_in = INDEX_W'(width_in) * INDEX_W'(height_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         four_ff   <= 1'b0;
         total_ff  <= INDEX_W'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         four_ff   <= four_in;
         total_ff  <= total_in;
      end
   end

   assign cfg.rearm     = rearm;
   assign cfg.four_byte = four_ff;
   assign cfg.total     = total_ff;

endmodule

@@ rtl/tga_rle_pixel_decoder_core.sv @@
// run-length tga pixel decoder: coded bytes in, colour spans out
//
// req_chan carries one byte of coded pixel data per word. Each byte
// updates the packet state; the byte that completes a pixel, or a packet
// header that would run past width*height pixels, yields one rsp_chan word.
// A span word holds the colour (red, green, blue, alpha), the repeat
// count and the linear index of its first pixel; image_done marks the
// last span, after which the decoder waits for the next image's header.
// An overflow word stops decoding until reset or a csr write.
// A result is valid in the cycle after its byte is accepted. Throughput is
// one byte per cycle, set by the combinational header/pixel state update
// that feeds the result register. req_chan.ready stays high while the result
// register is empty or being taken, so a stalled receiver holds at most
// one result and back-pressures the input only while it stalls.
// Reset (synchronous) restores width 1, height 1, 3-byte pixels and the
// start of an image. Any csr write to a defined register also restarts the
// image at pixel 0 and clears a latched overflow; csr writes are meant to
// happen only while no results are outstanding.
module tga_rle_pixel_decoder_core import trd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   trd_req_if.sink               req_chan,
   trd_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   logic               hdr_ff, hdr_in;
   logic               run_ff, run_in;
   logic [BYTE_W-1:0]  left_ff, left_in;
   logic [1:0]         byte_idx_ff, byte_idx_in;
   logic [BYTE_W-1:0]  held_ff [3];
   logic [BYTE_W-1:0]  held_in [3];
   logic [INDEX_W-1:0] pos_ff, pos_in;
   logic               error_ff, error_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff;

   logic               req_fire;
   logic [BYTE_W-1:0]  b;
   logic [BYTE_W-1:0]  count;
   logic [INDEX_W:0]   hdr_sum;
   logic [1:0]         last_idx;
   logic [BYTE_W-1:0]  span;
   logic [INDEX_W-1:0] new_pos;
   logic               res_valid;
   rsp_type            res;

   trd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input handshake: take a byte whenever the result register can be refilled
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;

   // header decode and overflow test
   assign count    = (b < RAW_LIMIT) ? (b + 8'd1) : (b - RUN_BIAS);
   assign hdr_sum  = {1'b0, pos_ff} + (INDEX_W + 1)'(count);
   assign last_idx = cfg.four_byte ? LAST_BYTE_4B : LAST_BYTE_3B;
   assign span     = run_ff ? left_ff : 8'd1;
   assign new_pos  = pos_ff + INDEX_W'(span);

   // per-byte state update
   always_comb begin
      hdr_in      = hdr_ff;
      run_in      = run_ff;
      left_in     = left_ff;
      byte_idx_in = byte_idx_ff;
      held_in     = held_ff;
      pos_in      = pos_ff;
      error_in    = error_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (req_fire && !error_ff) begin
         priority if (hdr_ff) begin
            if (hdr_sum > {1'b0, cfg.total}) begin
               res_valid       = 1'b1;
               res.overflow    = 1'b1;
               res.start_index = pos_ff;
               error_in        = 1'b1;
            end else begin
               run_in      = b[BYTE_W-1];
               left_in     = count;
               byte_idx_in = 2'd0;
               hdr_in      = 1'b0;
            end
         end else if (byte_idx_ff < last_idx) begin
            held_in[byte_idx_ff] = b;
            byte_idx_in          = byte_idx_ff + 2'd1;
         end else begin
            // last byte of a pixel closes one span
            res_valid       = 1'b1;
            res.blue        = held_ff[0];
            res.green       = held_ff[1];
            res.red         = cfg.four_byte ? held_ff[2] : b;
            res.alpha       = cfg.four_byte ? b : '0;
            res.span_length = span;
            res.start_index = pos_ff;
            byte_idx_in     = 2'd0;
            left_in         = run_ff ? '0 : (left_ff - 8'd1);
            hdr_in          = (left_in == '0);
            if (new_pos == cfg.total) begin
               res.image_done = 1'b1;
               pos_in         = '0;
               hdr_in         = 1'b1;
               left_in        = '0;
            end else begin
               pos_in = new_pos;
            end
         end
      end

      // a register write starts a new image
      if (cfg.rearm) begin
         hdr_in      = 1'b1;
         run_in      = 1'b0;
         left_in     = '0;
         byte_idx_in = 2'd0;
         pos_in      = '0;
         error_in    = 1'b0;
      end
   end

   // result register valid
   assign rsp_valid_in = req_chan.ready ? res_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff       <= 1'b1;
         run_ff       <= 1'b0;
         left_ff      <= '0;
         byte_idx_ff  <= 2'd0;
         pos_ff       <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_ff       <= hdr_in;
         run_ff       <= run_in;
         left_ff      <= left_in;
         byte_idx_ff  <= byte_idx_in;
         pos_ff       <= pos_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pixel bytes and result payload
   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (req_chan.ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   // output channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.red         = rsp_ff.red;
   assign rsp_chan.green       = rsp_ff.green;
   assign rsp_chan.blue        = rsp_ff.blue;
   assign rsp_chan.alpha       = rsp_ff.alpha;
   assign rsp_chan.span_length = rsp_ff.span_length;
   assign rsp_chan.start_index = rsp_ff.start_index;
   assign rsp_chan.image_done  = rsp_ff.image_done;
   assign rsp_chan.overflow    = rsp_ff.overflow;

   // pixel position never passes the pixel count
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= cfg.total)
      else $error("pixel position beyond image pixel count");

   // waiting for a header means no pixel or packet is half done
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      hdr_ff |-> (byte_idx_ff == 2'd0) && (left_ff == '0))
      else $error("header expected with packet state still active");

   // 3-byte pixels never reach the fourth byte slot
   a_byte_slot: assert property (@(posedge clock) disable iff (reset)
      !cfg.four_byte |-> (byte_idx_ff != LAST_BYTE_4B))
      else $error("fourth byte slot used for 3-byte pixels");

   // an overflow word leaves the decoder latched
   a_overflow_latch: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready && res_valid && res.overflow && !cfg.rearm |=> error_ff)
      else $error("overflow result without latched error");

endmodule
